### hw/rtl/lpcf_pkg.sv
// Shared types and constants for the length-prefixed chunk framer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lpcf_pkg;

    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int BYTE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_CHUNK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_CHUNK = 1'b1;

    localparam logic CMD_PAYLOAD = 1'b0;
    localparam logic CMD_CLOSE   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_HI,
        ST_HDR_LO,
        ST_RD,
        ST_DATA,
        ST_END_HI,
        ST_END_LO
    } state_t;

    typedef enum logic [1:0] {
        OSEL_ZERO,
        OSEL_LEN,
        OSEL_DATA
    } out_sel_t;

    typedef struct packed {
        logic     take_item;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     idx_clear;
        logic     idx_inc;
        logic     rd_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic chunk_go;
        logic marker_go;
        logic marker_pending;
        logic idx_last;
        logic slot_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/lpcf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module lpcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lpcf_ctrl.sv
// Controller state machine for the chunk framer: sequences header, data and
// end-marker bytes. Depends on lpcf_pkg for state, command and status types.
`default_nettype none

module lpcf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire lpcf_pkg::dp_status_t status,
    output lpcf_pkg::ctrl_cmd_t      cmd
);

    lpcf_pkg::state_t state_reg;
    lpcf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpcf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpcf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.chunk_go)
                    begin
                        state_next = lpcf_pkg::ST_HDR_HI;
                    end
                    else if (status.marker_go)
                    begin
                        state_next = lpcf_pkg::ST_END_HI;
                    end
                end
            end
            lpcf_pkg::ST_HDR_HI:
            begin
                if (status.slot_free)
                begin
                    state_next = lpcf_pkg::ST_HDR_LO;
                end
            end
            lpcf_pkg::ST_HDR_LO:
            begin
                if (status.slot_free)
                begin
                    state_next = lpcf_pkg::ST_RD;
                end
            end
            lpcf_pkg::ST_RD:
            begin
                state_next = lpcf_pkg::ST_DATA;
            end
            lpcf_pkg::ST_DATA:
            begin
                if (status.slot_free)
                begin
                    if (!status.idx_last)
                    begin
                        state_next = lpcf_pkg::ST_RD;
                    end
                    else if (status.marker_pending)
                    begin
                        state_next = lpcf_pkg::ST_END_HI;
                    end
                    else
                    begin
                        state_next = lpcf_pkg::ST_IDLE;
                    end
                end
            end
            lpcf_pkg::ST_END_HI:
            begin
                if (status.slot_free)
                begin
                    state_next = lpcf_pkg::ST_END_LO;
                end
            end
            lpcf_pkg::ST_END_LO:
            begin
                if (status.slot_free)
                begin
                    state_next = lpcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.out_sel  = lpcf_pkg::OSEL_ZERO;
        in_stall     = 1'b1;
        case (state_reg)
            lpcf_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.take_item = in_valid;
                cmd.idx_clear = 1'b1;
            end
            lpcf_pkg::ST_HDR_HI:
            begin
                cmd.out_load = status.slot_free;
            end
            lpcf_pkg::ST_HDR_LO:
            begin
                cmd.out_load = status.slot_free;
                cmd.out_sel  = lpcf_pkg::OSEL_LEN;
            end
            lpcf_pkg::ST_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            lpcf_pkg::ST_DATA:
            begin
                cmd.out_load = status.slot_free;
                cmd.out_sel  = lpcf_pkg::OSEL_DATA;
                cmd.out_last = status.idx_last && !status.marker_pending;
                cmd.idx_inc  = status.slot_free;
            end
            lpcf_pkg::ST_END_HI:
            begin
                cmd.out_load = status.slot_free;
            end
            lpcf_pkg::ST_END_LO:
            begin
                cmd.out_load = status.slot_free;
                cmd.out_last = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/lpcf_datapath.sv
// Datapath of the chunk framer: configuration registers, fill count, chunk
// store, read index and output register. Depends on lpcf_pkg and lpcf_ram.
`default_nettype none

module lpcf_datapath #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lpcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpcf_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          command,
    input  wire logic [lpcf_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                          end_of_write,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic      [lpcf_pkg::BYTE_W-1:0]   out_byte,
    output logic                               is_header,
    output logic                               last,
    input  wire lpcf_pkg::ctrl_cmd_t           cmd,
    output lpcf_pkg::dp_status_t               status
);

    localparam int CW    = $clog2(BUFFER_DEPTH + 1);
    localparam int AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CMP_W = (CW > lpcf_pkg::CFG_W) ? CW : lpcf_pkg::CFG_W;

    logic [lpcf_pkg::CFG_W-1:0] max_chunk_reg, max_chunk_next;
    logic [lpcf_pkg::CFG_W-1:0] min_chunk_reg, min_chunk_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       sent_reg, sent_next;
    logic [CW-1:0]              len_reg, len_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       marker_reg, marker_next;
    logic                       out_valid_reg, out_valid_next;
    logic [lpcf_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       is_header_reg, is_header_next;
    logic                       last_reg, last_next;

    logic                       has_room;
    logic [CW-1:0]              count_inc;
    logic [CMP_W-1:0]           max_ext;
    logic [CMP_W-1:0]           max_eff;
    logic [CMP_W-1:0]           count_inc_ext;
    logic                       chunk_go;
    logic                       marker_go;
    logic [lpcf_pkg::BYTE_W-1:0] rd_data;

    // Configuration registers.
    always_comb
    begin
        max_chunk_next = max_chunk_reg;
        min_chunk_next = min_chunk_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lpcf_pkg::CFG_IDX_MAX_CHUNK: max_chunk_next = cfg_data;
                lpcf_pkg::CFG_IDX_MIN_CHUNK: min_chunk_next = cfg_data;
                default:
                begin
                    max_chunk_next = max_chunk_reg;
                end
            endcase
        end
    end

    // A full store accepts no more bytes, but the count still decides emission.
    assign has_room      = (count_reg < CW'(BUFFER_DEPTH));
    assign count_inc     = has_room ? (count_reg + CW'(1)) : count_reg;
    assign count_inc_ext = CMP_W'(count_inc);
    assign max_ext       = CMP_W'(max_chunk_reg);

    always_comb
    begin
        if (max_ext == '0)
        begin
            max_eff = CMP_W'(1);
        end
        else if (max_ext > CMP_W'(BUFFER_DEPTH))
        begin
            max_eff = CMP_W'(BUFFER_DEPTH);
        end
        else
        begin
            max_eff = max_ext;
        end
    end

    always_comb
    begin
        if (command == lpcf_pkg::CMD_CLOSE)
        begin
            chunk_go  = (count_reg != '0);
            marker_go = sent_reg || (count_reg != '0);
        end
        else
        begin
            chunk_go  = (count_inc_ext >= max_eff)
                     || (end_of_write && (count_inc_ext >= CMP_W'(min_chunk_reg)));
            marker_go = 1'b0;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        sent_next   = sent_reg;
        len_next    = len_reg;
        marker_next = marker_reg;
        if (cmd.take_item)
        begin
            marker_next = marker_go;
            if (command == lpcf_pkg::CMD_CLOSE)
            begin
                count_next = '0;
                sent_next  = 1'b0;
                len_next   = count_reg;
            end
            else if (chunk_go)
            begin
                count_next = '0;
                sent_next  = 1'b1;
                len_next   = count_inc;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    lpcf_ram #(
        .WIDTH (lpcf_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.take_item && (command == lpcf_pkg::CMD_PAYLOAD) && has_room),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (data_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Output register: a new item may load whenever it is empty or the current one is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        is_header_next = is_header_reg;
        last_next      = last_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.out_last;
            case (cmd.out_sel)
                lpcf_pkg::OSEL_LEN:
                begin
                    out_byte_next  = lpcf_pkg::BYTE_W'(len_reg);
                    is_header_next = 1'b1;
                end
                lpcf_pkg::OSEL_DATA:
                begin
                    out_byte_next  = rd_data;
                    is_header_next = 1'b0;
                end
                default:
                begin
                    out_byte_next  = '0;
                    is_header_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunk_reg <= lpcf_pkg::CFG_W'(32);
            min_chunk_reg <= '0;
            count_reg     <= '0;
            sent_reg      <= 1'b0;
            marker_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_chunk_reg <= max_chunk_next;
            min_chunk_reg <= min_chunk_next;
            count_reg     <= count_next;
            sent_reg      <= sent_next;
            marker_reg    <= marker_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        out_byte_reg  <= out_byte_next;
        is_header_reg <= is_header_next;
        last_reg      <= last_next;
    end

    assign status.chunk_go       = chunk_go;
    assign status.marker_go      = marker_go;
    assign status.marker_pending = marker_reg;
    assign status.idx_last       = (idx_reg == (len_reg - CW'(1)));
    assign status.slot_free      = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_header = is_header_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### hw/rtl/length_prefixed_chunk_framer_unit.sv
// Top level of the length-prefixed chunk framer.
// Instantiates lpcf_ctrl and lpcf_datapath; types come from lpcf_pkg.
//
// The framer takes one item at a time: a payload byte or a close command.
// A payload byte that does not finish a chunk is stored at acceptance and the
// input is ready again in the next cycle. A chunk of L bytes goes out as a
// two-byte length header and the L bytes; each data byte is first read
// through the store's registered read port and then loaded into the output
// register. A close adds the two-byte 0x0000 end marker. The input is held
// off until the last result of an item has been loaded; that result may
// still wait in the output register while the next item is accepted.
`default_nettype none

module length_prefixed_chunk_framer_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lpcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpcf_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic [lpcf_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                          end_of_write,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [lpcf_pkg::BYTE_W-1:0]   out_byte,
    output logic                               is_header,
    output logic                               last
);

    lpcf_pkg::ctrl_cmd_t  cmd;
    lpcf_pkg::dp_status_t status;

    lpcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lpcf_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .data_byte    (data_byte),
        .end_of_write (end_of_write),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .is_header    (is_header),
        .last         (last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

### hw/rtl/lpcf_checker.sv
// Port-level checker for the chunk framer, bound to the top level.
// Depends on lpcf_pkg for port widths.
`default_nettype none

module lpcf_checker #(
    parameter int BUFFER_DEPTH = 32
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [lpcf_pkg::BYTE_W-1:0] out_byte,
    input wire logic                        is_header,
    input wire logic                        last
);

    // A stalled result must hold until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(is_header) && $stable(last))
    else $error("stalled result changed");

    // The only header byte that ends an item is the second end-marker byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_header && last |-> out_byte == '0)
    else $error("last header byte is not an end marker");

    // A nonzero header byte is a chunk length, which never exceeds the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_header && out_byte != '0
            |-> out_byte <= lpcf_pkg::BYTE_W'(BUFFER_DEPTH))
    else $error("chunk length out of range");

    // While an item still has results to produce, no new item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
    else $error("input accepted before an item finished");

endmodule

bind length_prefixed_chunk_framer_unit lpcf_checker #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
) u_lpcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_header (is_header),
    .last      (last)
);

`default_nettype wire

### tb/length_prefixed_chunk_framer_unit_tb.sv
// Self-checking testbench for length_prefixed_chunk_framer_unit.
// Holds a byte-exact framing predictor in a small scoreboard class; depends on
// lpcf_pkg and the framer RTL only.
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0] value;
    logic       hdr;
    logic       last;
} framed_byte_t;

class chunk_frame_scoreboard;
    localparam int DEPTH = 32;

    logic [7:0]   store [DEPTH];
    int unsigned  held_bytes;
    bit           chunk_sent;
    logic [5:0]   max_reg;
    logic [5:0]   min_reg;
    framed_byte_t framed_bytes[$];
    int unsigned  items_noted;
    int unsigned  bytes_checked;
    int unsigned  mismatches;

    function void clear_state();
        held_bytes = 0;
        chunk_sent = 0;
        max_reg    = 6'd32;
        min_reg    = 6'd0;
    endfunction

    function void write_reg(logic [lpcf_pkg::CFG_IDX_W-1:0] idx, logic [5:0] value);
        if (idx == lpcf_pkg::CFG_IDX_MAX_CHUNK)
            max_reg = value;
        else
            min_reg = value;
    endfunction

    function void queue_byte(logic [7:0] value, logic hdr);
        framed_byte_t fb;
        fb.value = value;
        fb.hdr   = hdr;
        fb.last  = 1'b0;
        framed_bytes.push_back(fb);
    endfunction

    // Length header (high byte first) followed by the held payload bytes.
    function void queue_chunk();
        queue_byte(8'(held_bytes >> 8), 1'b1);
        queue_byte(8'(held_bytes), 1'b1);
        for (int i = 0; i < held_bytes; i++)
            queue_byte(store[i], 1'b0);
        held_bytes = 0;
        chunk_sent = 1'b1;
    endfunction

    function void note_item(logic cmd, logic [7:0] data, logic eow);
        int unsigned first;
        int unsigned limit;
        first = framed_bytes.size();
        items_noted++;
        if (cmd == lpcf_pkg::CMD_CLOSE)
        begin
            // A close with nothing held and nothing sent produces no output.
            if (chunk_sent || held_bytes != 0)
            begin
                if (held_bytes != 0)
                    queue_chunk();
                queue_byte(8'h00, 1'b1);
                queue_byte(8'h00, 1'b1);
            end
            held_bytes = 0;
            chunk_sent = 1'b0;
        end
        else
        begin
            limit = (max_reg == 0) ? 1 : ((max_reg > DEPTH) ? DEPTH : max_reg);
            if (held_bytes < DEPTH)
            begin
                store[held_bytes] = data;
                held_bytes++;
            end
            if (held_bytes >= limit)
                queue_chunk();
            else if (eow && held_bytes > 0 && held_bytes >= min_reg)
                queue_chunk();
        end
        if (framed_bytes.size() > first)
            framed_bytes[framed_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(logic [7:0] value, logic hdr, logic last_flag);
        framed_byte_t want;
        bytes_checked++;
        if (framed_bytes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected output byte %02h hdr %b last %b",
                         value, hdr, last_flag);
            return;
        end
        want = framed_bytes.pop_front();
        if (want.value !== value || want.hdr !== hdr || want.last !== last_flag)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: output byte %0d: expected %02h hdr %b last %b, ",
                         bytes_checked, want.value, want.hdr, want.last,
                         "got %02h hdr %b last %b", value, hdr, last_flag);
        end
    endfunction
endclass

module length_prefixed_chunk_framer_unit_tb;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_write    = 1'b0;
    logic [lpcf_pkg::CFG_IDX_W-1:0] cfg_index    = lpcf_pkg::CFG_IDX_MAX_CHUNK;
    logic [lpcf_pkg::CFG_W-1:0]     cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic                           command      = lpcf_pkg::CMD_PAYLOAD;
    logic [lpcf_pkg::BYTE_W-1:0]    data_byte    = '0;
    logic                           end_of_write = 1'b0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic [lpcf_pkg::BYTE_W-1:0]    out_byte;
    logic                           is_header;
    logic                           last;

    logic quiet_mode        = 1'b0;
    logic long_hold_request = 1'b0;
    bit   long_hold_done    = 1'b0;
    int   hold_left         = 0;
    int   settings_used     = 0;

    chunk_frame_scoreboard frames;

    length_prefixed_chunk_framer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .data_byte    (data_byte),
        .end_of_write (end_of_write),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_header    (is_header),
        .last         (last)
    );

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Output side: random stalls except in quiet mode, one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (long_hold_request && !long_hold_done)
        begin
            hold_left      = 300;
            long_hold_done = 1'b1;
            out_stall <= 1'b1;
        end
        else if (quiet_mode)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 23);
    end

    // Inputs only change at rising edges, so the falling edge sees exactly
    // what the next rising edge will accept.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            frames.check_byte(out_byte, is_header, last);
    end

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(logic cmd, logic [7:0] data, logic eow);
        if (!quiet_mode && $urandom_range(0, 99) < 23)
        begin
            in_valid     <= 1'b0;
            command      <= 1'($urandom_range(0, 1));
            data_byte    <= 8'($urandom_range(0, 255));
            end_of_write <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        data_byte    <= data;
        end_of_write <= eow;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        frames.note_item(cmd, data, eow);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (frames.framed_bytes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_limits(logic [5:0] max_value, logic [5:0] min_value);
        cfg_write <= 1'b1;
        cfg_index <= lpcf_pkg::CFG_IDX_MAX_CHUNK;
        cfg_data  <= max_value;
        frames.write_reg(lpcf_pkg::CFG_IDX_MAX_CHUNK, max_value);
        @(posedge clk);
        cfg_index <= lpcf_pkg::CFG_IDX_MIN_CHUNK;
        cfg_data  <= min_value;
        frames.write_reg(lpcf_pkg::CFG_IDX_MIN_CHUNK, min_value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Mostly well-formed writes (end-of-write on the final byte), with
    // occasional ragged writes and closes carrying random ignored fields.
    task automatic frame_traffic(int unsigned n_items);
        int unsigned count;
        int unsigned len;
        bit          ragged;
        logic        eow;
        count = 0;
        while (count < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_item(lpcf_pkg::CMD_CLOSE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                count++;
            end
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 70);
            else
                len = $urandom_range(1, 12);
            // The final write is cut short so the item count stays on budget.
            if (len > n_items - count)
                len = n_items - count;
            ragged = ($urandom_range(0, 99) < 15);
            for (int i = 0; i < len; i++)
            begin
                eow = ragged ? 1'($urandom_range(0, 1)) : (i == len - 1);
                send_item(lpcf_pkg::CMD_PAYLOAD, 8'($urandom_range(0, 255)), eow);
                count++;
            end
        end
    endtask

    initial
    begin
        frames = new();
        frames.clear_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small chunks so that every framing case fits in a few items.
        set_limits(6'd4, 6'd2);
        send_item(lpcf_pkg::CMD_CLOSE, 8'hFF, 1'b1);     // close while idle
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'h00, 1'b1);   // tail below min is held
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'hFF, 1'b0);
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'hA5, 1'b1);   // tail reaches min
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'h5A, 1'b0);
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'h01, 1'b0);
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'h80, 1'b0);
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'h7F, 1'b1);   // fills a chunk and ends a write
        send_item(lpcf_pkg::CMD_CLOSE, 8'h00, 1'b0);     // end marker only
        send_item(lpcf_pkg::CMD_CLOSE, 8'h00, 1'b0);     // idle again
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'h33, 1'b0);
        send_item(lpcf_pkg::CMD_CLOSE, 8'hFF, 1'b1);     // held bytes, then end marker
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'hC3, 1'b1);
        send_item(lpcf_pkg::CMD_PAYLOAD, 8'h3C, 1'b1);
        send_item(lpcf_pkg::CMD_CLOSE, 8'h55, 1'b1);
        drain();

        quiet_mode <= 1'b1;
        set_limits(6'd32, 6'd0);
        frame_traffic(60);
        quiet_mode <= 1'b0;
        drain();

        set_limits(6'd1, 6'd0);
        frame_traffic(35);
        drain();

        set_limits(6'd0, 6'd7);
        frame_traffic(25);
        drain();

        // Oversized limits; the long hold-off lets the input back up.
        set_limits(6'd63, 6'd40);
        long_hold_request <= 1'b1;
        frame_traffic(60);
        drain();

        set_limits(6'd5, 6'd3);
        frame_traffic(45);
        drain();

        set_limits(6'd17, 6'd17);
        frame_traffic(45);
        drain();

        set_limits(6'd8, 6'd63);
        frame_traffic(35);
        drain();

        set_limits(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        frame_traffic(50);
        drain();

        set_limits(6'd32, 6'd32);
        frame_traffic(35);
        drain();

        $display("Framed %0d input items under %0d limit settings ",
                 frames.items_noted, settings_used,
                 "into %0d checked output bytes.", frames.bytes_checked);
        $display("Mismatches: %0d; output bytes still outstanding: %0d.",
                 frames.mismatches, frames.framed_bytes.size());
        if (frames.mismatches == 0 && frames.framed_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
